[rtl/core/mfd_pkg.sv]
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared types and constants of the motor feedback packet deframer.
// ----------------------------------------------------------------------------
package mfd_pkg;

    // Default sizes handed to the top level
    localparam int FRAME_DEPTH_DEF   = 32;
    localparam int PAYLOAD_LIMIT_DEF = 32;

    // Only frame bytes 0..18 are ever read back, so only those are kept
    localparam int STORE_DEPTH = 19;
    localparam int STORE_IDX_W = $clog2(STORE_DEPTH);

    // Depth of the op queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Frame byte offsets of the result fields
    localparam int TYPE_OFS = 3;
    localparam int LSPD_OFS = 5;
    localparam int LPOS_OFS = 7;
    localparam int RSPD_OFS = 13;
    localparam int RPOS_OFS = 15;

    // Configuration register indexes
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_HOST_ID     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DRV_NODE_ID = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FRONT_ID    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_REAR_ID     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MAIN_TYPE   = 3'd4;

    // Configuration reset values
    localparam logic [7:0] HOST_ID_RST     = 8'd184;
    localparam logic [7:0] DRV_NODE_ID_RST = 8'd183;
    localparam logic [7:0] FRONT_ID_RST    = 8'd1;
    localparam logic [7:0] REAR_ID_RST     = 8'd2;
    localparam logic [7:0] MAIN_TYPE_RST   = 8'd193;

    typedef struct packed {
        logic [7:0] host_id;
        logic [7:0] drv_node_id;
        logic [7:0] front_id;
        logic [7:0] rear_id;
        logic [7:0] main_type;
    } mfd_cfg_t;

    // What the back end does with a byte
    typedef enum logic [1:0] {
        OP_DROP        = 2'd0,  // discard, clear sum
        OP_ACCEPT      = 2'd1,  // add to sum, store
        OP_ACCEPT_HUNT = 2'd2,  // store, then clear sum
        OP_CHECK       = 2'd3   // store, test sum, maybe emit, clear sum
    } mfd_kind_t;

    typedef struct packed {
        logic [7:0]             data;
        mfd_kind_t              kind;
        logic                   store_en;
        logic [STORE_IDX_W-1:0] store_idx;
        logic                   drv_ok;
        logic                   which;
    } mfd_op_t;

endpackage

[rtl/core/mfd_front.sv]
// ----------------------------------------------------------------------------
// mfd_front
// Frame parser: tracks header, driver, type, length, data and checksum phases
// and turns each received word into one op for the back end.
// ----------------------------------------------------------------------------
module mfd_front #(
    parameter int FRAME_DEPTH   = mfd_pkg::FRAME_DEPTH_DEF,
    parameter int PAYLOAD_LIMIT = mfd_pkg::PAYLOAD_LIMIT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mfd_pkg::mfd_cfg_t  cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_byte,
    output logic               op_valid,
    input  logic               op_ready,
    output mfd_pkg::mfd_op_t   op
);
    import mfd_pkg::*;

    localparam int CNT_W  = $clog2(FRAME_DEPTH + 1);
    localparam int PCNT_W = $clog2(PAYLOAD_LIMIT + 1);

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_DRIVER = 6'b000010,
        PH_TYPE   = 6'b000100,
        PH_LENGTH = 6'b001000,
        PH_DATA   = 6'b010000,
        PH_CHECK  = 6'b100000
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [PCNT_W-1:0]   pcnt_reg, pcnt_next;
    logic [7:0]          plen_reg, plen_next;
    logic [7:0]          src_reg, src_next;

    logic [CNT_W-1:0]    cnt_inc;
    logic [PCNT_W-1:0]   pcnt_inc;
    logic                store_ok;
    logic                take;

    assign in_ready = op_ready;
    assign op_valid = in_valid;
    assign take     = in_valid && op_ready;

    assign cnt_inc  = cnt_reg + 1'b1;
    assign pcnt_inc = pcnt_reg + 1'b1;
    assign store_ok = (cnt_reg < CNT_W'(STORE_DEPTH));

    // Phase decode and op build
    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        pcnt_next    = pcnt_reg;
        plen_next    = plen_reg;
        src_next     = src_reg;
        op.data      = in_byte;
        op.kind      = OP_DROP;
        op.store_en  = 1'b0;
        op.store_idx = cnt_reg[STORE_IDX_W-1:0];
        op.drv_ok    = 1'b0;
        op.which     = 1'b0;

        if (cnt_reg >= CNT_W'(FRAME_DEPTH))
        begin
            // frame full: word discarded
            phase_next = PH_HEADER;
            cnt_next   = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (in_byte == cfg.host_id || in_byte == cfg.drv_node_id)
                    begin
                        op.kind     = OP_ACCEPT;
                        op.store_en = store_ok;
                        cnt_next    = cnt_inc;
                        if (cnt_inc >= CNT_W'(2))
                            phase_next = PH_DRIVER;
                    end
                    else
                    begin
                        phase_next = PH_HEADER;
                        cnt_next   = '0;
                    end
                end
                PH_DRIVER:
                begin
                    if (in_byte == cfg.front_id || in_byte == cfg.rear_id)
                    begin
                        op.kind     = OP_ACCEPT;
                        op.store_en = store_ok;
                        cnt_next    = cnt_inc;
                        src_next    = in_byte;
                        phase_next  = PH_TYPE;
                    end
                    else
                    begin
                        phase_next = PH_HEADER;
                        cnt_next   = '0;
                    end
                end
                PH_TYPE:
                begin
                    op.kind     = OP_ACCEPT;
                    op.store_en = store_ok;
                    cnt_next    = cnt_inc;
                    phase_next  = PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    op.kind     = OP_ACCEPT;
                    op.store_en = store_ok;
                    cnt_next    = cnt_inc;
                    plen_next   = in_byte;
                    pcnt_next   = '0;
                    phase_next  = PH_DATA;
                end
                PH_DATA:
                begin
                    op.store_en = store_ok;
                    pcnt_next   = pcnt_inc;
                    if (pcnt_inc >= PCNT_W'(PAYLOAD_LIMIT))
                    begin
                        // payload overflow
                        op.kind    = OP_ACCEPT_HUNT;
                        phase_next = PH_HEADER;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        op.kind  = OP_ACCEPT;
                        cnt_next = cnt_inc;
                        if ({{(9 - PCNT_W){1'b0}}, pcnt_inc} >= {1'b0, plen_reg})
                            phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    op.kind     = OP_CHECK;
                    op.store_en = store_ok;
                    phase_next  = PH_HEADER;
                    cnt_next    = '0;
                    // front wins when both IDs are equal
                    priority if (src_reg == cfg.front_id)
                    begin
                        op.drv_ok = 1'b1;
                        op.which  = 1'b0;
                    end
                    else if (src_reg == cfg.rear_id)
                    begin
                        op.drv_ok = 1'b1;
                        op.which  = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                    cnt_next   = '0;
                end
            endcase
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            cnt_reg   <= '0;
            pcnt_reg  <= '0;
            plen_reg  <= '0;
            src_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            pcnt_reg  <= pcnt_next;
            plen_reg  <= plen_next;
            src_reg   <= src_next;
        end
    end

endmodule

[rtl/core/mfd_queue.sv]
// ----------------------------------------------------------------------------
// mfd_queue
// Short op queue that decouples the parser from the result builder.
// ----------------------------------------------------------------------------
module mfd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  mfd_pkg::mfd_op_t  push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output mfd_pkg::mfd_op_t  pop_data
);
    import mfd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    mfd_op_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push, pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[rtl/core/mfd_back.sv]
// ----------------------------------------------------------------------------
// mfd_back
// Result builder: keeps the running checksum and the frame bytes, and
// loads the output register when a good feedback frame completes.
// ----------------------------------------------------------------------------
module mfd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  mfd_pkg::mfd_cfg_t  cfg,
    input  logic               op_valid,
    output logic               op_ready,
    input  mfd_pkg::mfd_op_t   op,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               which_driver,
    output logic signed [15:0] left_speed_rpm,
    output logic signed [31:0] left_position_ticks,
    output logic signed [15:0] right_speed_rpm,
    output logic signed [31:0] right_position_ticks
);
    import mfd_pkg::*;

    logic [7:0]          sum_reg, sum_next;
    logic [7:0]          store_reg [STORE_DEPTH];
    logic [7:0]          view [STORE_DEPTH];
    logic [7:0]          sum_add;
    logic                out_valid_reg, out_valid_next;
    logic                which_reg;
    logic signed [15:0]  lspd_reg, rspd_reg;
    logic signed [31:0]  lpos_reg, rpos_reg;
    logic                pop, good, load;

    // A check word waits while an unread result sits in the output register
    assign op_ready = (op.kind != OP_CHECK) || !out_valid_reg || out_ready;
    assign pop      = op_valid && op_ready;
    assign sum_add  = sum_reg + op.data;

    // Store contents with the word being written folded in
    always_comb
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
            view[i] = (op.store_en && op.store_idx == STORE_IDX_W'(i)) ? op.data
                                                                        : store_reg[i];
    end

    assign good = (op.kind == OP_CHECK) && (sum_add == 8'd0) && op.drv_ok
               && (view[TYPE_OFS] == cfg.main_type);
    assign load = pop && good;

    // Checksum
    always_comb
    begin
        sum_next = sum_reg;
        if (pop)
        begin
            unique case (op.kind)
                OP_ACCEPT:      sum_next = sum_add;
                OP_DROP,
                OP_ACCEPT_HUNT,
                OP_CHECK:       sum_next = 8'd0;
                default:        sum_next = 8'd0;
            endcase
        end
    end

    // Output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < STORE_DEPTH; i++)
                store_reg[i] <= '0;
        end
        else
        begin
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            if (pop && op.store_en)
                store_reg[op.store_idx] <= op.data;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            which_reg <= op.which;
            lspd_reg  <= {view[LSPD_OFS + 1], view[LSPD_OFS]};
            lpos_reg  <= {view[LPOS_OFS + 3], view[LPOS_OFS + 2],
                          view[LPOS_OFS + 1], view[LPOS_OFS]};
            rspd_reg  <= {view[RSPD_OFS + 1], view[RSPD_OFS]};
            rpos_reg  <= {view[RPOS_OFS + 3], view[RPOS_OFS + 2],
                          view[RPOS_OFS + 1], view[RPOS_OFS]};
        end
    end

    assign out_valid            = out_valid_reg;
    assign which_driver         = which_reg;
    assign left_speed_rpm       = lspd_reg;
    assign left_position_ticks  = lpos_reg;
    assign right_speed_rpm      = rspd_reg;
    assign right_position_ticks = rpos_reg;

`ifndef SYNTHESIS
    // a result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!out_valid_reg || out_ready))
        else $error("result overwritten while output stalled");

    // every frame end or drop leaves a clean checksum
    a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && op.kind != OP_ACCEPT) |=> (sum_reg == 8'd0))
        else $error("checksum not cleared after frame end");

    // a good check word always shows a result next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg)
        else $error("good frame produced no result");
`endif

endmodule

[rtl/core/motor_feedback_packet_deframer_core.sv]
// ----------------------------------------------------------------------------
// motor_feedback_packet_deframer_core
// Deframes motor driver feedback packets from a received byte stream and
// reports speed and encoder position per driver.
//
//   channel   dir  fields
//   s_axis    in   tdata[7:0] rx_byte
//   m_axis    out  tuser[0] which_driver; tdata left_speed_rpm, left_position_ticks,
//                  right_speed_rpm, right_position_ticks
//   cfg       in   cfg_we / cfg_index / cfg_data, write only
//
// One word per cycle is taken while s_axis_tready is high; the parser does one
// compare-and-count step per word. The checksum word passes through the op queue,
// and a good frame then loads the output register that drives m_axis_tvalid.
// s_axis_tready drops only when the two-entry op queue fills, which happens
// when a finished frame waits behind an unread result in the output register.
// Reset loads the default IDs and zeroes the frame bytes at once.
// ----------------------------------------------------------------------------
module motor_feedback_packet_deframer_core #(
    parameter int FRAME_DEPTH   = mfd_pkg::FRAME_DEPTH_DEF,
    parameter int PAYLOAD_LIMIT = mfd_pkg::PAYLOAD_LIMIT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_we,
    input  logic [mfd_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    // received bytes
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] rx_byte
    // feedback results
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [15:0] left_speed_rpm, [47:16] left_position_ticks,
    // [63:48] right_speed_rpm, [95:64] right_position_ticks
    output logic [95:0]                   m_axis_tdata,
    output logic [0:0]                    m_axis_tuser    // [0] which_driver
);
    import mfd_pkg::*;

    mfd_cfg_t           cfg_reg, cfg_next;
    logic               op_in_valid, op_in_ready;
    mfd_op_t            op_in;
    logic               op_out_valid, op_out_ready;
    mfd_op_t            op_out;
    logic               which;
    logic signed [15:0] lspd, rspd;
    logic signed [31:0] lpos, rpos;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HOST_ID:     cfg_next.host_id     = cfg_data;
                REG_DRV_NODE_ID: cfg_next.drv_node_id = cfg_data;
                REG_FRONT_ID:    cfg_next.front_id    = cfg_data;
                REG_REAR_ID:     cfg_next.rear_id     = cfg_data;
                REG_MAIN_TYPE:   cfg_next.main_type   = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.host_id     <= HOST_ID_RST;
            cfg_reg.drv_node_id <= DRV_NODE_ID_RST;
            cfg_reg.front_id    <= FRONT_ID_RST;
            cfg_reg.rear_id     <= REAR_ID_RST;
            cfg_reg.main_type   <= MAIN_TYPE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Parser
    mfd_front #(
        .FRAME_DEPTH   (FRAME_DEPTH),
        .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .op_valid (op_in_valid),
        .op_ready (op_in_ready),
        .op       (op_in)
    );

    // Op queue
    mfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (op_in_valid),
        .push_ready (op_in_ready),
        .push_data  (op_in),
        .pop_valid  (op_out_valid),
        .pop_ready  (op_out_ready),
        .pop_data   (op_out)
    );

    // Result builder
    mfd_back u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg                  (cfg_reg),
        .op_valid             (op_out_valid),
        .op_ready             (op_out_ready),
        .op                   (op_out),
        .out_valid            (m_axis_tvalid),
        .out_ready            (m_axis_tready),
        .which_driver         (which),
        .left_speed_rpm       (lspd),
        .left_position_ticks  (lpos),
        .right_speed_rpm      (rspd),
        .right_position_ticks (rpos)
    );

    assign m_axis_tdata = {rpos, rspd, lpos, lspd};
    assign m_axis_tuser = which;

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for motor_feedback_packet_deframer_core. Received bytes
// are fed as framed feedback packets, broken packets and line noise under
// several ID settings. A byte-level parser model predicts each speed and
// position report. Reports are checked field by field as they leave the core.
// Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

    import mfd_pkg::*;

    localparam int FRAME_DEPTH   = FRAME_DEPTH_DEF;
    localparam int PAYLOAD_LIMIT = PAYLOAD_LIMIT_DEF;
    localparam int SETTLE_CYCLES = 8;     // lets the op queue empty after the last report

    typedef enum logic [2:0] {
        HUNT_HEADER,
        WAIT_DRIVER,
        WAIT_TYPE,
        WAIT_LENGTH,
        IN_PAYLOAD,
        WAIT_CHECKSUM
    } parse_state_t;

    typedef struct packed {
        logic               which;
        logic signed [15:0] left_speed;
        logic signed [31:0] left_pos;
        logic signed [15:0] right_speed;
        logic signed [31:0] right_pos;
    } feedback_t;

    // DUT ports; the inputs are all driven known from time zero
    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index     = '0;
    logic [7:0]           cfg_data      = 8'd0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = 8'd0;   // [7:0] rx_byte
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [15:0] left speed, [47:16] left position, [63:48] right speed,
    // [95:64] right position
    logic [95:0]          m_axis_tdata;
    logic [0:0]           m_axis_tuser;           // [0] which_driver

    // Parser model state
    mfd_cfg_t     cfg;
    parse_state_t parse_state;
    int           frame_count;
    logic [7:0]   frame_sum;
    int           payload_seen;
    logic [7:0]   payload_len;
    logic [7:0]   src_driver;
    logic [7:0]   frame_store [FRAME_DEPTH];

    feedback_t    expected_feedback [$];
    int           mismatch_count = 0;

    // Stimulus state
    logic [7:0]   frame_bytes [$];
    int           bytes_sent   = 0;
    bit           sender_gaps  = 1'b1;
    int           burst_left   = 0;
    logic [15:0]  ready_pattern = 16'hFFFF;
    int           pattern_age  = 0;
    feedback_t    got_fb;
    feedback_t    exp_fb;

    motor_feedback_packet_deframer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------
    task automatic restart_hunt();
        parse_state = HUNT_HEADER;
        frame_count = 0;
        frame_sum   = 8'd0;
    endtask

    task automatic take_byte(input logic [7:0] b);
        frame_sum = frame_sum + b;
        if (frame_count < FRAME_DEPTH)
            frame_store[frame_count] = b;
        frame_count++;
    endtask

    // One received byte; queues a feedback report when a good main-data
    // frame completes for a known driver
    task automatic parse_feedback_byte(input logic [7:0] b);
        logic      frame_good;
        feedback_t fb;
        frame_good = 1'b0;
        // frame full: byte dropped, back to hunting
        if (frame_count >= FRAME_DEPTH)
        begin
            restart_hunt();
            return;
        end
        case (parse_state)
            HUNT_HEADER:
            begin
                if (b == cfg.host_id || b == cfg.drv_node_id)
                begin
                    take_byte(b);
                    if (frame_count >= 2)
                        parse_state = WAIT_DRIVER;
                end
                else
                    restart_hunt();
            end
            WAIT_DRIVER:
            begin
                if (b == cfg.front_id || b == cfg.rear_id)
                begin
                    src_driver = b;
                    take_byte(b);
                    parse_state = WAIT_TYPE;
                end
                else
                    restart_hunt();
            end
            WAIT_TYPE:
            begin
                take_byte(b);
                parse_state = WAIT_LENGTH;
            end
            WAIT_LENGTH:
            begin
                payload_len  = b;
                payload_seen = 0;
                take_byte(b);
                parse_state = IN_PAYLOAD;
            end
            IN_PAYLOAD:
            begin
                take_byte(b);
                payload_seen++;
                // zero length still takes one byte
                if (payload_seen >= PAYLOAD_LIMIT)
                    restart_hunt();
                else if (payload_seen >= payload_len)
                    parse_state = WAIT_CHECKSUM;
            end
            WAIT_CHECKSUM:
            begin
                take_byte(b);
                frame_good = (frame_sum == 8'd0);
                restart_hunt();
            end
            default:
                restart_hunt();
        endcase

        // driver ID is matched against the IDs in force now, front first
        if (frame_good && frame_store[TYPE_OFS] == cfg.main_type
            && (src_driver == cfg.front_id || src_driver == cfg.rear_id))
        begin
            fb.which       = (src_driver != cfg.front_id);
            fb.left_speed  = {frame_store[LSPD_OFS+1], frame_store[LSPD_OFS]};
            fb.left_pos    = {frame_store[LPOS_OFS+3], frame_store[LPOS_OFS+2],
                              frame_store[LPOS_OFS+1], frame_store[LPOS_OFS]};
            fb.right_speed = {frame_store[RSPD_OFS+1], frame_store[RSPD_OFS]};
            fb.right_pos   = {frame_store[RPOS_OFS+3], frame_store[RPOS_OFS+2],
                              frame_store[RPOS_OFS+1], frame_store[RPOS_OFS]};
            expected_feedback = {expected_feedback, fb};
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_fb.which       = m_axis_tuser[0];
            got_fb.left_speed  = m_axis_tdata[15:0];
            got_fb.left_pos    = m_axis_tdata[47:16];
            got_fb.right_speed = m_axis_tdata[63:48];
            got_fb.right_pos   = m_axis_tdata[95:64];
            if (expected_feedback.size() == 0)
                note_failure($sformatf(
                    "unexpected report: which=%0d ls=%0d lp=%0d rs=%0d rp=%0d",
                    got_fb.which, got_fb.left_speed, got_fb.left_pos,
                    got_fb.right_speed, got_fb.right_pos));
            else
            begin
                exp_fb = expected_feedback.pop_front();
                if (got_fb.which !== exp_fb.which
                    || got_fb.left_speed !== exp_fb.left_speed
                    || got_fb.left_pos !== exp_fb.left_pos
                    || got_fb.right_speed !== exp_fb.right_speed
                    || got_fb.right_pos !== exp_fb.right_pos)
                    note_failure($sformatf("report mismatch: %s / %s",
                        $sformatf("exp which=%0d ls=%0d lp=%0d rs=%0d rp=%0d",
                            exp_fb.which, exp_fb.left_speed, exp_fb.left_pos,
                            exp_fb.right_speed, exp_fb.right_pos),
                        $sformatf("got which=%0d ls=%0d lp=%0d rs=%0d rp=%0d",
                            got_fb.which, got_fb.left_speed, got_fb.left_pos,
                            got_fb.right_speed, got_fb.right_pos)));
            end
        end
    end

    // Receiver back-pressure: rotating ready pattern, reloaded now and then
    always @(posedge clk)
    begin
        if (pattern_age == 0)
        begin
            case ($urandom_range(0, 3))
                0: ready_pattern = 16'hFFFF;
                1: ready_pattern = 16'($urandom_range(0, 65535)) | 16'h0001;
                2: ready_pattern = 16'h0001;
                default: ready_pattern = 16'hF0F0;
            endcase
            pattern_age = $urandom_range(20, 200);
        end
        else
            pattern_age--;
        ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
        m_axis_tready <= ready_pattern[0];
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_rx_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            if (sender_gaps)
            begin
                gap = $urandom_range(1, 6);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        parse_feedback_byte(b);
        bytes_sent++;
    endtask

    // Hold off until every report is in, then let the pipe settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_feedback.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
    endtask

    // Only called with the core idle
    task automatic set_config(input mfd_cfg_t c);
        write_reg(REG_HOST_ID,     c.host_id);
        write_reg(REG_DRV_NODE_ID, c.drv_node_id);
        write_reg(REG_FRONT_ID,    c.front_id);
        write_reg(REG_REAR_ID,     c.rear_id);
        write_reg(REG_MAIN_TYPE,   c.main_type);
        cfg_we <= 1'b0;
        cfg = c;
    endtask

    // Header, driver, type, length and random payload; no checksum yet
    task automatic build_frame(input logic [7:0] h0, h1, drv, typ, len);
        int n;
        frame_bytes.delete();
        frame_bytes = {frame_bytes, h0};
        frame_bytes = {frame_bytes, h1};
        frame_bytes = {frame_bytes, drv};
        frame_bytes = {frame_bytes, typ};
        frame_bytes = {frame_bytes, len};
        n = (len == 0) ? 1 : ((len > 34) ? 34 : len);
        repeat (n) frame_bytes = {frame_bytes, 8'($urandom_range(0, 255))};
    endtask

    task automatic put_word(input int ofs, input logic [31:0] v, input int n);
        for (int k = 0; k < n; k++)
            frame_bytes[ofs + k] = v[8*k +: 8];
    endtask

    // Appends checksum (offset by sum_err) and sends the first keep bytes, or all if keep < 0
    task automatic send_frame(input logic [7:0] sum_err, input int keep);
        logic [7:0] s;
        int         last;
        s = 8'd0;
        foreach (frame_bytes[i])
            s = s + frame_bytes[i];
        frame_bytes = {frame_bytes, 8'(8'd0 - s + sum_err)};
        last = (keep < 0) ? frame_bytes.size() : keep;
        for (int i = 0; i < last; i++)
            send_rx_byte(frame_bytes[i]);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Zero-length frame right after reset: unread offsets come back zero
    task automatic test_zero_length_after_reset();
        build_frame(cfg.host_id, cfg.drv_node_id, cfg.front_id, cfg.main_type, 8'd0);
        frame_bytes[5] = 8'h00;
        send_frame(8'd0, -1);
        drain_results();
    endtask

    // Field extremes, then a short frame that reads stale bytes
    task automatic test_extremes_and_stale_bytes();
        build_frame(cfg.drv_node_id, cfg.host_id, cfg.rear_id, cfg.main_type, 8'd14);
        put_word(5, 32'h8000, 2);
        put_word(7, 32'h7FFF_FFFF, 4);
        put_word(13, 32'h7FFF, 2);
        put_word(15, 32'h8000_0000, 4);
        send_frame(8'd0, -1);
        build_frame(cfg.host_id, cfg.host_id, cfg.front_id, cfg.main_type, 8'd14);
        for (int k = 5; k < 19; k++)
            frame_bytes[k] = 8'hFF;
        send_frame(8'd0, -1);
        build_frame(cfg.drv_node_id, cfg.drv_node_id, cfg.front_id, cfg.main_type, 8'd3);
        send_frame(8'd0, -1);
        drain_results();
    endtask

    // Other type, bad checksum, unknown driver, bad header; then a good one
    task automatic test_rejected_frames();
        build_frame(cfg.host_id, cfg.drv_node_id, cfg.front_id, cfg.main_type + 8'd1, 8'd0);
        send_frame(8'd0, -1);
        build_frame(cfg.host_id, cfg.drv_node_id, cfg.rear_id, cfg.main_type, 8'd0);
        send_frame(8'h01, -1);
        build_frame(cfg.host_id, cfg.drv_node_id, 8'h7E, cfg.main_type, 8'd0);
        send_frame(8'd0, -1);
        build_frame(cfg.host_id, 8'h00, cfg.front_id, cfg.main_type, 8'd0);
        send_frame(8'd0, -1);
        build_frame(cfg.host_id, cfg.drv_node_id, cfg.rear_id, cfg.main_type, 8'd1);
        send_frame(8'd0, -1);
        drain_results();
    endtask

    // Length beyond the frame store: frame full drops back to hunting
    task automatic test_frame_overflow();
        build_frame(cfg.host_id, cfg.drv_node_id, cfg.front_id, cfg.main_type, 8'd40);
        send_frame(8'd0, -1);
        build_frame(cfg.host_id, cfg.drv_node_id, cfg.front_id, cfg.main_type, 8'd255);
        send_frame(8'd0, -1);
        build_frame(cfg.host_id, cfg.drv_node_id, cfg.front_id, cfg.main_type, 8'd2);
        send_frame(8'd0, -1);
        drain_results();
    endtask

    // Driver IDs and main type changed while a frame is open, before its checksum
    task automatic test_driver_id_rematch();
        mfd_cfg_t c;
        // front ID moves away, byte now matches rear
        build_frame(cfg.host_id, cfg.drv_node_id, cfg.front_id, cfg.main_type, 8'd0);
        send_frame(8'd0, 6);
        drain_results();
        c = cfg;
        c.rear_id  = cfg.front_id;
        c.front_id = 8'd9;
        set_config(c);
        send_rx_byte(frame_bytes[6]);
        drain_results();
        // equal IDs report front
        c.front_id = 8'd5;
        c.rear_id  = 8'd5;
        set_config(c);
        build_frame(cfg.host_id, cfg.drv_node_id, 8'd5, cfg.main_type, 8'd0);
        send_frame(8'd0, -1);
        // neither ID matches any more
        build_frame(cfg.host_id, cfg.drv_node_id, 8'd5, cfg.main_type, 8'd0);
        send_frame(8'd0, 6);
        drain_results();
        c.front_id = 8'd6;
        c.rear_id  = 8'd7;
        set_config(c);
        send_rx_byte(frame_bytes[6]);
        drain_results();
        // main type changed while open
        build_frame(cfg.host_id, cfg.drv_node_id, 8'd7, cfg.main_type, 8'd0);
        send_frame(8'd0, 6);
        drain_results();
        c.main_type = cfg.main_type + 8'd3;
        set_config(c);
        send_rx_byte(frame_bytes[6]);
        drain_results();
    endtask

    task automatic random_frame();
        logic [7:0] h0, h1, drv, typ, len, sum_err;
        int         pick, keep;
        h0   = $urandom_range(0, 1) ? cfg.host_id : cfg.drv_node_id;
        h1   = $urandom_range(0, 1) ? cfg.host_id : cfg.drv_node_id;
        pick = $urandom_range(0, 9);
        drv  = (pick < 5) ? cfg.front_id : ((pick < 9) ? cfg.rear_id : 8'($urandom));
        typ  = ($urandom_range(0, 7) != 0) ? cfg.main_type : 8'($urandom);
        pick = $urandom_range(0, 19);
        if (pick < 14)
            len = 8'($urandom_range(14, 19));
        else if (pick < 17)
            len = 8'($urandom_range(0, 13));
        else if (pick < 19)
            len = 8'($urandom_range(20, 40));
        else
            len = 8'($urandom_range(0, 255));
        build_frame(h0, h1, drv, typ, len);
        sum_err = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
        keep = ($urandom_range(0, 11) == 0) ? $urandom_range(1, frame_bytes.size()) : -1;
        send_frame(sum_err, keep);
    endtask

    // Mostly well-formed frames with random content, plus noise
    task automatic run_random_traffic(input int n_bytes);
        int start;
        int n;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
        begin
            sender_gaps = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    send_rx_byte($urandom_range(0, 1) ? 8'($urandom) : cfg.host_id);
            end
            random_frame();
            if ($urandom_range(0, 29) == 0)
                drain_results();
        end
        drain_results();
    endtask

    // Random traffic under default, random and extreme ID settings
    task automatic test_random_settings();
        mfd_cfg_t c;
        sender_gaps = 1'b1;
        c = '{HOST_ID_RST, DRV_NODE_ID_RST, FRONT_ID_RST, REAR_ID_RST, MAIN_TYPE_RST};
        set_config(c);
        run_random_traffic(250);
        c = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
        set_config(c);
        run_random_traffic(300);
        set_config('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        run_random_traffic(300);
        set_config('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        run_random_traffic(300);
        set_config('{8'hAA, 8'hAA, 8'h55, 8'h55, 8'h00});
        run_random_traffic(300);
        c = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
        set_config(c);
        run_random_traffic(300);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        cfg = '{HOST_ID_RST, DRV_NODE_ID_RST, FRONT_ID_RST, REAR_ID_RST, MAIN_TYPE_RST};
        payload_seen = 0;
        payload_len  = 8'd0;
        src_driver   = 8'd0;
        foreach (frame_store[i])
            frame_store[i] = 8'd0;
        restart_hunt();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_length_after_reset();
        test_extremes_and_stale_bytes();
        test_rejected_frames();
        test_frame_overflow();
        test_driver_id_rematch();
        test_random_settings();

        drain_results();
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
